// ===== hw/rtl/wfpa_pkg.sv =====
// Package: widths, entry layout and table sizes for the worst-fit allocator.
`timescale 1ns / 1ps
package wfpa_pkg;
    localparam int MAX_ENTRIES = 256;
    localparam int OWNER_BITS  = 10;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ADDR_W      = 40;
    localparam int REQ_W       = 24;
    localparam int PCNT_W      = 32;
    localparam logic [REQ_W-1:0] PAGE_RESET = REQ_W'(4096);

    typedef struct packed {
        logic [ADDR_W-1:0]     base;
        logic [ADDR_W-1:0]     len;
        logic [OWNER_BITS-1:0] owner;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
endpackage

// ===== hw/rtl/wfpa_req_if.sv =====
// Request channel interface: kind, owner tag and byte count.
`timescale 1ns / 1ps
interface wfpa_req_if import wfpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [OWNER_BITS-1:0] owner;
    logic [REQ_W-1:0]      req_bytes;
    modport source (output valid, kind, owner, req_bytes, input ready);
    modport sink   (input valid, kind, owner, req_bytes, output ready);
endinterface

// ===== hw/rtl/wfpa_rsp_if.sv =====
// Result channel interface: page count, largest free partition, status.
`timescale 1ns / 1ps
interface wfpa_rsp_if import wfpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PCNT_W-1:0] pages_total;
    logic [ADDR_W-1:0] largest_free_size;
    logic [ADDR_W-1:0] largest_free_addr;
    logic              status;
    modport source (output valid, pages_total, largest_free_size, largest_free_addr, status,
                    input ready);
    modport sink   (input valid, pages_total, largest_free_size, largest_free_addr, status,
                    output ready);
endinterface

// ===== hw/rtl/wfpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/wfpa_div.sv =====
// Restoring divider, one quotient bit per cycle, for page rounding.
`timescale 1ns / 1ps
module wfpa_div import wfpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REQ_W-1:0] i_num,
    input  logic [REQ_W-1:0] i_den,
    output logic             o_done,
    output logic [REQ_W-1:0] o_quo,
    output logic [REQ_W-1:0] o_rem
);
    localparam int CW = $clog2(REQ_W + 1);

    logic [REQ_W-1:0] r_quo;
    logic [REQ_W:0]   r_rem;
    logic [REQ_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [REQ_W:0]   sh;
    logic             take;

    assign sh   = {r_rem[REQ_W-1:0], r_quo[REQ_W-1]};
    assign take = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_quo <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CW'(REQ_W);
            end else if (r_cnt != '0) begin
                r_rem <= take ? (sh - {1'b0, r_den}) : sh;
                r_quo <= {r_quo[REQ_W-2:0], take};
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[REQ_W-1:0];
endmodule

// ===== hw/rtl/worst_fit_partition_allocator.sv =====
// Top level: worst-fit partition table sequencer around one RAM and a divider.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-----------------------------------------------
//  i_req    | in  | valid/ready      | kind, owner, req_bytes
//  o_rsp    | out | valid/ready      | pages_total, largest_free_size/addr, status
//  i_cfg    | in  | write enable     | page_bytes (24 bit)
//
// An allocate runs a worst-fit scan, shifts entries to make room for a split, runs the
// page divider when memory grows, and ends with a closing scan; a free releases and
// merges entries in one pass over the table, then runs the closing scan.
// Every pass goes through the single RAM read port, one entry at a time.
// Reset clears the count and page counter; table contents need no clearing.
// A finished result waits in the output register; a new item is taken meanwhile.
`timescale 1ns / 1ps
module worst_fit_partition_allocator import wfpa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [REQ_W-1:0] i_cfg_data,
    wfpa_req_if.sink         i_req,
    wfpa_rsp_if.source       o_rsp
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_GO   = 4'd1;
    localparam logic [3:0] S_DIV_WAIT = 4'd2;
    localparam logic [3:0] S_GROW_WR1 = 4'd3;
    localparam logic [3:0] S_GROW_WR2 = 4'd4;
    localparam logic [3:0] S_SCAN_GO  = 4'd5;
    localparam logic [3:0] S_SCAN_RD  = 4'd6;
    localparam logic [3:0] S_SCAN_CHK = 4'd7;
    localparam logic [3:0] S_DECIDE   = 4'd8;
    localparam logic [3:0] S_SHIFT_RD = 4'd9;
    localparam logic [3:0] S_SHIFT_WR = 4'd10;
    localparam logic [3:0] S_INS_WR   = 4'd11;
    localparam logic [3:0] S_FREE_RD  = 4'd12;
    localparam logic [3:0] S_FREE_CHK = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    logic [3:0]            r_state;
    logic [REQ_W-1:0]      r_page_bytes;
    logic [OWNER_BITS-1:0] r_own;
    logic [REQ_W-1:0]      r_req;
    logic [CNT_W-1:0]      r_count;
    logic [PCNT_W-1:0]     r_pages;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_w;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best;
    logic [ADDR_W-1:0]     r_best_base;
    logic [ADDR_W-1:0]     r_best_len;
    t_entry                r_last;
    t_entry                r_hold;
    logic                  r_phase;
    logic                  r_init;
    logic                  r_full;
    logic [ADDR_W-1:0]     r_rem;
    logic [REQ_W-1:0]      r_dnum;
    logic [IDX_W-1:0]      r_a1;
    t_entry                r_e1;
    t_entry                r_e2;
    logic                  r_do2;
    logic                  r_ovalid;
    logic [PCNT_W-1:0]     r_o_pages;
    logic [ADDR_W-1:0]     r_o_size;
    logic [ADDR_W-1:0]     r_o_addr;
    logic                  r_o_status;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    t_entry                rd;
    logic                  div_done;
    logic [REQ_W-1:0]      div_quo;
    logic [REQ_W-1:0]      div_rem;
    logic [REQ_W-1:0]      pg;
    logic [ADDR_W-1:0]     req_x;
    logic                  fit;
    logic [ADDR_W-1:0]     fit_rem;
    logic                  fit_full;
    logic                  last_idx;
    t_entry                fe;
    logic                  merge;
    t_entry                hold_m;
    logic [REQ_W:0]        pg_p;
    logic [REQ_W-1:0]      grow_rem;
    logic                  grow_has;
    logic [PCNT_W:0]       pg_sum;
    logic [PCNT_W-1:0]     pages_sat;
    logic [ADDR_W-1:0]     app_base;
    logic                  grow_full;

    assign pg       = (r_page_bytes == '0) ? REQ_W'(1) : r_page_bytes;
    assign rd       = t_entry'(ram_rdata);
    assign req_x    = {{(ADDR_W-REQ_W){1'b0}}, r_req};
    assign fit      = r_found && (r_best_len >= req_x);
    assign fit_rem  = r_best_len - req_x;
    assign fit_full = (fit_rem != '0) && (r_count == MAX_CNT);
    assign last_idx = (r_idx + 1'b1) == r_count;

    always_comb begin
        fe = rd;
        if (rd.owner == r_own) begin
            fe.owner = '0;
        end
    end
    assign merge = (fe.owner == '0) && (r_w != '0) && (r_hold.owner == '0);
    always_comb begin
        hold_m     = r_hold;
        hold_m.len = r_hold.len + fe.len;
    end

    // page rounding: pages = ceil(n / pg), leftover bytes = pg - n mod pg (zero if n mod pg is zero)
    assign grow_has  = div_rem != '0;
    assign pg_p      = {1'b0, div_quo} + {{REQ_W{1'b0}}, grow_has};
    assign grow_rem  = grow_has ? (pg - div_rem) : '0;
    assign pg_sum    = {1'b0, r_pages} + (PCNT_W + 1)'(pg_p);
    assign pages_sat = pg_sum[PCNT_W] ? '1 : pg_sum[PCNT_W-1:0];
    assign app_base  = r_last.base + r_last.len;
    assign grow_full = (r_last.owner == '0)
        ? (grow_has && (r_count == MAX_CNT))
        : ((r_count + CNT_W'(1) + CNT_W'(grow_has)) > MAX_CNT);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best;
        ram_wdata = r_e1;
        case (r_state)
            S_DECIDE: begin
                if (fit && !fit_full) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{r_best_base, req_x, r_own};
                end
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[IDX_W-1:0] + 1'b1;
                ram_wdata = rd;
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_best + 1'b1;
                ram_wdata = '{r_best_base + req_x, r_rem, {OWNER_BITS{1'b0}}};
            end
            S_GROW_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = r_a1;
            end
            S_GROW_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = r_a1 + 1'b1;
                ram_wdata = r_e2;
            end
            S_FREE_CHK: begin
                ram_we = 1'b1;
                if (merge) begin
                    ram_waddr = r_w[IDX_W-1:0] - 1'b1;
                    ram_wdata = hold_m;
                end else begin
                    ram_waddr = r_w[IDX_W-1:0];
                    ram_wdata = fe;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    wfpa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    wfpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (r_dnum),
        .i_den   (pg),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= PAGE_RESET;
        end else if (i_cfg_we) begin
            r_page_bytes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pages  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_ovalid && o_rsp.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_own   <= i_req.owner;
                        r_req   <= i_req.req_bytes;
                        r_dnum  <= i_req.req_bytes;
                        r_full  <= 1'b0;
                        r_idx   <= '0;
                        r_w     <= '0;
                        r_init  <= (i_req.owner != '0) && !i_req.kind && (r_count == '0);
                        r_phase <= !((i_req.owner != '0) && !i_req.kind && (r_count != '0));
                        if (i_req.owner == '0) begin
                            r_state <= S_SCAN_GO;
                        end else if (i_req.kind) begin
                            r_state <= (r_count == '0) ? S_SCAN_GO : S_FREE_RD;
                        end else if (r_count == '0) begin
                            r_state <= S_DIV_GO;
                        end else begin
                            r_state <= S_SCAN_GO;
                        end
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (r_init) begin
                            r_pages <= pages_sat;
                            r_a1    <= '0;
                            r_e1    <= '{'0, ADDR_W'(r_dnum) + ADDR_W'(grow_rem), '0};
                            r_do2   <= 1'b0;
                            r_count <= CNT_W'(1);
                            r_state <= S_GROW_WR1;
                        end else if (grow_full) begin
                            r_full  <= 1'b1;
                            r_phase <= 1'b1;
                            r_state <= S_SCAN_GO;
                        end else begin
                            r_pages <= pages_sat;
                            r_do2   <= grow_has;
                            r_state <= S_GROW_WR1;
                            if (r_last.owner == '0) begin
                                r_a1    <= r_count[IDX_W-1:0] - 1'b1;
                                r_e1    <= '{r_last.base, req_x, r_own};
                                r_e2    <= '{r_last.base + req_x, ADDR_W'(grow_rem), '0};
                                r_count <= r_count + CNT_W'(grow_has);
                            end else begin
                                r_a1    <= r_count[IDX_W-1:0];
                                r_e1    <= '{app_base, req_x, r_own};
                                r_e2    <= '{app_base + req_x, ADDR_W'(grow_rem), '0};
                                r_count <= r_count + CNT_W'(1) + CNT_W'(grow_has);
                            end
                        end
                    end
                end
                S_GROW_WR1: begin
                    if (r_do2) begin
                        r_state <= S_GROW_WR2;
                    end else begin
                        r_phase <= !r_init;
                        r_state <= S_SCAN_GO;
                    end
                end
                S_GROW_WR2: begin
                    r_phase <= 1'b1;
                    r_state <= S_SCAN_GO;
                end
                S_SCAN_GO: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (r_count == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (rd.owner == '0 && (!r_found || rd.len > r_best_len)) begin
                        r_found     <= 1'b1;
                        r_best      <= r_idx[IDX_W-1:0];
                        r_best_base <= rd.base;
                        r_best_len  <= rd.len;
                    end
                    if (last_idx) begin
                        r_last  <= rd;
                        r_state <= r_phase ? S_DONE : S_DECIDE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DECIDE: begin
                    if (fit) begin
                        if (fit_full) begin
                            r_full  <= 1'b1;
                            r_phase <= 1'b1;
                            r_state <= S_SCAN_GO;
                        end else if (fit_rem == '0) begin
                            r_phase <= 1'b1;
                            r_state <= S_SCAN_GO;
                        end else begin
                            r_rem <= fit_rem;
                            r_idx <= r_count - 1'b1;
                            if ({1'b0, r_best} + 1'b1 == r_count) begin
                                r_state <= S_INS_WR;
                            end else begin
                                r_state <= S_SHIFT_RD;
                            end
                        end
                    end else begin
                        // grow memory: extend a free tail or append pages
                        r_dnum  <= (r_last.owner == '0) ? (r_req - r_last.len[REQ_W-1:0])
                                                       : r_req;
                        r_state <= S_DIV_GO;
                    end
                end
                S_SHIFT_RD: begin
                    r_state <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    if (r_idx == {1'b0, r_best} + 1'b1) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_SHIFT_RD;
                    end
                end
                S_INS_WR: begin
                    r_count <= r_count + 1'b1;
                    r_phase <= 1'b1;
                    r_state <= S_SCAN_GO;
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    if (merge) begin
                        r_hold <= hold_m;
                    end else begin
                        r_hold <= fe;
                    end
                    if (last_idx) begin
                        r_count <= r_w + CNT_W'(!merge);
                        r_phase <= 1'b1;
                        r_state <= S_SCAN_GO;
                    end else begin
                        r_w     <= r_w + CNT_W'(!merge);
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_FREE_RD;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_pages  <= r_pages;
                        r_o_size   <= r_found ? r_best_len : '0;
                        r_o_addr   <= r_found ? r_best_base : '0;
                        r_o_status <= r_full;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready             = r_state == S_IDLE;
    assign o_rsp.valid             = r_ovalid;
    assign o_rsp.pages_total       = r_o_pages;
    assign o_rsp.largest_free_size = r_o_size;
    assign o_rsp.largest_free_addr = r_o_addr;
    assign o_rsp.status            = r_o_status;
endmodule
